// ===== hw/rtl/spf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes of the SPI receive deframer.
// No dependencies; used by the controller, output register and top level.
package spf_pkg;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_PKT_LONG  = 4'd1;
  localparam logic [3:0] ST_PKT_SHORT = 4'd2;
  localparam logic [3:0] ST_SOF_BAD   = 4'd3;
  localparam logic [3:0] ST_EOF_BAD   = 4'd4;
  localparam logic [3:0] ST_ETH_SHORT = 4'd5;
  localparam logic [3:0] ST_ETH_LONG  = 4'd6;
  localparam logic [3:0] ST_RESYNC    = 4'd7;
  localparam logic [3:0] ST_FLUSHED   = 4'd8;

  localparam logic [1:0] RT_HOMEPLUG = 2'd0;
  localparam logic [1:0] RT_IPV6     = 2'd1;
  localparam logic [1:0] RT_IPV4     = 2'd2;
  localparam logic [1:0] RT_OTHER    = 2'd3;

  localparam logic [15:0] ET_HOMEPLUG = 16'h88E1;
  localparam logic [15:0] ET_IPV6     = 16'h86DD;
  localparam logic [15:0] ET_IPV4     = 16'h0800;

  localparam logic [7:0] SOF_BYTE = 8'hAA;
  localparam logic [7:0] EOF_BYTE = 8'h55;

  localparam int HDR_READ  = 10;
  localparam int HDR_BYTES = 12;
  localparam int ET_OFS    = 24;

  localparam logic [1:0] REG_MAX_PKT = 2'd0;
  localparam logic [1:0] REG_MIN_BUF = 2'd1;
  localparam logic [1:0] REG_MIN_ETH = 2'd2;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] eth_length;
    logic [15:0] ether_type;
    logic [1:0]  route;
    logic [10:0] skipped_bytes;
    logic        ipv6_seen;
    logic        last;
  } rep_t;

  typedef struct packed {
    logic [10:0] max_packet_len;
    logic [10:0] min_buffer_len;
    logic [10:0] min_eth_len;
  } cfg_t;

endpackage

// ===== hw/rtl/spf_store.sv =====
`timescale 1ns / 1ps
// Frame store: single-port-write, single-port-read byte memory.
// Read data is registered. No package dependency.
module spf_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/spf_outreg.sv =====
`timescale 1ns / 1ps
// Output register of the report stream.
// Depends on spf_pkg for the report type.
module spf_outreg (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  spf_pkg::rep_t push_rep,
  output logic         free,
  input  logic         ready,
  output logic         valid,
  output spf_pkg::rep_t rep
);

  logic          valid_r;
  spf_pkg::rep_t rep_r;

  assign free  = !valid_r || ready;
  assign valid = valid_r;
  assign rep   = rep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rep_r <= push_rep;
    end
  end

endmodule

// ===== hw/rtl/spf_ctrl.sv =====
`timescale 1ns / 1ps
// Parse sequencer: keeps the ring pointers and walks the frame store byte by byte.
// Depends on spf_pkg; drives spf_store and spf_outreg.
module spf_ctrl #(
  parameter int DEPTH = 2048,
  parameter int MAXR  = 16,
  parameter int AW    = $clog2(DEPTH),
  parameter int FW    = $clog2(DEPTH + 1),
  parameter int NW    = $clog2(MAXR + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  spf_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_func,
  input  logic [7:0]    in_byte,
  output logic          we,
  output logic [AW-1:0] waddr,
  output logic [7:0]    wdata,
  output logic          re,
  output logic [AW-1:0] raddr,
  input  logic [7:0]    rdata,
  output logic          push,
  output spf_pkg::rep_t push_rep,
  input  logic          out_free
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_TOP  = 5'd1;
  localparam logic [4:0] S_HRD  = 5'd2;
  localparam logic [4:0] S_HCAP = 5'd3;
  localparam logic [4:0] S_CHK  = 5'd4;
  localparam logic [4:0] S_EI1  = 5'd5;
  localparam logic [4:0] S_EC1  = 5'd6;
  localparam logic [4:0] S_EI2  = 5'd7;
  localparam logic [4:0] S_EC2  = 5'd8;
  localparam logic [4:0] S_CHK2 = 5'd9;
  localparam logic [4:0] S_TI1  = 5'd10;
  localparam logic [4:0] S_TC1  = 5'd11;
  localparam logic [4:0] S_TI2  = 5'd12;
  localparam logic [4:0] S_TC2  = 5'd13;
  localparam logic [4:0] S_EMIT = 5'd14;
  localparam logic [4:0] S_SCI  = 5'd15;
  localparam logic [4:0] S_SCC  = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  logic [4:0]    state_r, state_nxt, tgt_r, tgt_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt, k_r, k_nxt, t_r, t_nxt;
  logic          ipv6_r, ipv6_nxt, held_v_r, held_v_nxt, pend_v_r, pend_v_nxt;
  logic [3:0]    held_st_r, held_st_nxt, st_r, st_nxt;
  logic [FW-1:0] held_sk_r, held_sk_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [31:0]   pl_r, pl_nxt;
  logic          mk_bad_r, mk_bad_nxt, e_bad_r, e_bad_nxt;
  logic [15:0]   eth_r, eth_nxt;
  logic [7:0]    hi_r, hi_nxt;
  logic [2:0]    run_r, run_nxt;
  spf_pkg::rep_t rep_r, rep_nxt, pend_r, pend_nxt;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [FW-1:0] o);
    logic [AW+1:0] s;
    s = (AW+2)'(h) + (AW+2)'(o);
    if (s >= (AW+2)'(DEPTH)) s = s - (AW+2)'(DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic logic [10:0] sat(input logic [FW-1:0] x);
    return (32'(x) > 32'd2047) ? 11'h7FF : 11'(x);
  endfunction

  // Read offset for each issuing state.
  logic [FW-1:0] rd_off;
  always_comb begin
    re     = 1'b0;
    rd_off = k_r;
    case (state_r)
      S_HRD: re = 1'b1;
      S_SCI: re = (k_r < fill_r);
      S_EI1: begin re = 1'b1; rd_off = t_r - FW'(2); end
      S_EI2: begin re = 1'b1; rd_off = t_r - FW'(1); end
      S_TI1: begin re = 1'b1; rd_off = FW'(spf_pkg::ET_OFS); end
      S_TI2: begin re = 1'b1; rd_off = FW'(spf_pkg::ET_OFS + 1); end
      default: re = 1'b0;
    endcase
  end
  assign raddr    = wrap(head_r, rd_off);
  assign in_ready = (state_r == S_IDLE);
  assign waddr    = wrap(head_r, fill_r);
  assign wdata    = in_byte;
  assign we       = in_valid && in_ready && !in_func && (fill_r < FW'(DEPTH));

  logic [32:0] tw;
  logic        c1, c2, c4, c5, c6;
  logic [15:0] et;
  logic [7:0]  lo;
  logic [1:0]  rt;
  logic        nv6;
  logic [FW-1:0] skip_i;

  always_comb begin
    state_nxt   = state_r;
    tgt_nxt     = tgt_r;
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    k_nxt       = k_r;
    t_nxt       = t_r;
    ipv6_nxt    = ipv6_r;
    held_v_nxt  = held_v_r;
    held_st_nxt = held_st_r;
    held_sk_nxt = held_sk_r;
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    st_nxt      = st_r;
    n_nxt       = n_r;
    pl_nxt      = pl_r;
    mk_bad_nxt  = mk_bad_r;
    e_bad_nxt   = e_bad_r;
    eth_nxt     = eth_r;
    hi_nxt      = hi_r;
    run_nxt     = run_r;
    rep_nxt     = rep_r;
    push        = 1'b0;
    push_rep    = pend_r;
    tw  = {1'b0, pl_r} + 33'd4;
    c1  = (pl_r > 32'(cfg.max_packet_len)) || (tw > 33'(DEPTH));
    c2  = (cfg.min_buffer_len >= 11'd4) && (pl_r < 32'(cfg.min_buffer_len - 11'd4));
    c4  = e_bad_r;
    c5  = eth_r < 16'(cfg.min_eth_len);
    c6  = eth_r > 16'(cfg.max_packet_len);
    lo  = (FW'(spf_pkg::ET_OFS + 1) < t_r) ? rdata : 8'd0;
    et  = {hi_r, lo};
    rt  = spf_pkg::RT_OTHER;
    nv6 = ipv6_r;
    if (et == spf_pkg::ET_HOMEPLUG) rt = spf_pkg::RT_HOMEPLUG;
    else if (et == spf_pkg::ET_IPV6) begin rt = spf_pkg::RT_IPV6; nv6 = 1'b1; end
    else if (et == spf_pkg::ET_IPV4) rt = spf_pkg::RT_IPV4;
    skip_i = k_r - FW'(7);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt = '0;
          if (in_func) begin
            rep_nxt = '{status: spf_pkg::ST_FLUSHED, eth_length: 16'd0, ether_type: 16'd0,
                        route: 2'd0, skipped_bytes: sat(fill_r), ipv6_seen: ipv6_r,
                        last: 1'b0};
            fill_nxt   = '0;
            held_v_nxt = 1'b0;
            tgt_nxt    = S_DONE;
            state_nxt  = S_EMIT;
          end else begin
            if (fill_r < FW'(DEPTH)) fill_nxt = fill_r + FW'(1);
            state_nxt = S_TOP;
          end
        end
      end
      S_TOP: begin
        // The report budget of one word is spent; the rest waits for the next word.
        if (n_r == NW'(MAXR)) begin
          state_nxt = S_DONE;
        end else if (held_v_r) begin
          rep_nxt = '{status: held_st_r, eth_length: 16'd0, ether_type: 16'd0,
                      route: 2'd0, skipped_bytes: sat(held_sk_r), ipv6_seen: ipv6_r,
                      last: 1'b0};
          held_v_nxt = 1'b0;
          tgt_nxt    = S_TOP;
          state_nxt  = S_EMIT;
        end else if ((32'(fill_r) < 32'(cfg.min_buffer_len)) ||
                     (fill_r < FW'(spf_pkg::HDR_BYTES))) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt      = '0;
          mk_bad_nxt = 1'b0;
          state_nxt  = S_HRD;
        end
      end
      S_HRD: state_nxt = S_HCAP;
      S_HCAP: begin
        if (k_r < FW'(4)) pl_nxt = {pl_r[23:0], rdata};
        else if (k_r < FW'(8)) mk_bad_nxt = mk_bad_r || (rdata != spf_pkg::SOF_BYTE);
        else if (k_r == FW'(8)) eth_nxt = {eth_r[15:8], rdata};
        else eth_nxt = {rdata, eth_r[7:0]};
        k_nxt     = k_r + FW'(1);
        state_nxt = (k_r == FW'(spf_pkg::HDR_READ - 1)) ? S_CHK : S_HRD;
      end
      S_CHK: begin
        t_nxt = FW'(tw);
        if (c1) begin st_nxt = spf_pkg::ST_PKT_LONG; state_nxt = S_CHK2; end
        else if (c2) begin st_nxt = spf_pkg::ST_PKT_SHORT; state_nxt = S_CHK2; end
        else if (mk_bad_r) begin st_nxt = spf_pkg::ST_SOF_BAD; state_nxt = S_CHK2; end
        else if (33'(fill_r) < tw) state_nxt = S_DONE;
        else begin st_nxt = spf_pkg::ST_OK; state_nxt = S_EI1; end
      end
      S_EI1: state_nxt = S_EC1;
      S_EC1: begin e_bad_nxt = (rdata != spf_pkg::EOF_BYTE); state_nxt = S_EI2; end
      S_EI2: state_nxt = S_EC2;
      S_EC2: begin
        e_bad_nxt = e_bad_r || (rdata != spf_pkg::EOF_BYTE);
        state_nxt = S_CHK2;
      end
      S_CHK2: begin
        // Header errors arrive here with st_r already set; end and length checks follow.
        if (st_r == spf_pkg::ST_OK) begin
          if (c4) st_nxt = spf_pkg::ST_EOF_BAD;
          else if (c5) st_nxt = spf_pkg::ST_ETH_SHORT;
          else if (c6) st_nxt = spf_pkg::ST_ETH_LONG;
        end
        if ((st_r == spf_pkg::ST_OK) && !c4 && !c5 && !c6) begin
          state_nxt = S_TI1;
        end else begin
          rep_nxt = '{status: (st_r != spf_pkg::ST_OK) ? st_r :
                              (c4 ? spf_pkg::ST_EOF_BAD :
                               (c5 ? spf_pkg::ST_ETH_SHORT : spf_pkg::ST_ETH_LONG)),
                      eth_length: eth_r, ether_type: 16'd0, route: 2'd0,
                      skipped_bytes: 11'd0, ipv6_seen: ipv6_r, last: 1'b0};
          k_nxt     = FW'(5);
          run_nxt   = '0;
          tgt_nxt   = S_SCI;
          state_nxt = S_EMIT;
        end
      end
      S_TI1: state_nxt = S_TC1;
      S_TC1: begin
        hi_nxt    = (FW'(spf_pkg::ET_OFS) < t_r) ? rdata : 8'd0;
        state_nxt = S_TI2;
      end
      S_TI2: state_nxt = S_TC2;
      S_TC2: begin
        ipv6_nxt = nv6;
        rep_nxt  = '{status: spf_pkg::ST_OK, eth_length: eth_r, ether_type: et, route: rt,
                     skipped_bytes: 11'd0, ipv6_seen: nv6, last: 1'b0};
        head_nxt  = wrap(head_r, t_r);
        fill_nxt  = fill_r - t_r;
        tgt_nxt   = S_TOP;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!pend_v_r || out_free) begin
          push       = pend_v_r;
          pend_nxt   = rep_r;
          pend_v_nxt = 1'b1;
          n_nxt      = n_r + NW'(1);
          if ((tgt_r == S_TOP) && (n_r + NW'(1) == NW'(MAXR))) state_nxt = S_DONE;
          else state_nxt = tgt_r;
        end
      end
      S_SCI: begin
        if (k_r >= fill_r) begin
          held_v_nxt  = 1'b1;
          held_st_nxt = spf_pkg::ST_FLUSHED;
          held_sk_nxt = fill_r;
          fill_nxt    = '0;
          state_nxt   = S_TOP;
        end else begin
          state_nxt = S_SCC;
        end
      end
      S_SCC: begin
        if ((rdata == spf_pkg::SOF_BYTE) && (run_r == 3'd3)) begin
          // Four marker bytes end at offset k, so the frame starts at k - 7.
          head_nxt    = wrap(head_r, skip_i);
          fill_nxt    = fill_r - skip_i;
          held_v_nxt  = 1'b1;
          held_st_nxt = spf_pkg::ST_RESYNC;
          held_sk_nxt = skip_i;
          state_nxt   = S_TOP;
        end else begin
          run_nxt   = (rdata == spf_pkg::SOF_BYTE) ? run_r + 3'd1 : 3'd0;
          k_nxt     = k_r + FW'(1);
          state_nxt = S_SCI;
        end
      end
      S_DONE: begin
        push_rep      = pend_r;
        push_rep.last = 1'b1;
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      fill_r   <= '0;
      ipv6_r   <= 1'b0;
      held_v_r <= 1'b0;
      pend_v_r <= 1'b0;
      n_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      fill_r   <= fill_nxt;
      ipv6_r   <= ipv6_nxt;
      held_v_r <= held_v_nxt;
      pend_v_r <= pend_v_nxt;
      n_r      <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r     <= tgt_nxt;
    k_r       <= k_nxt;
    t_r       <= t_nxt;
    held_st_r <= held_st_nxt;
    held_sk_r <= held_sk_nxt;
    pend_r    <= pend_nxt;
    st_r      <= st_nxt;
    pl_r      <= pl_nxt;
    mk_bad_r  <= mk_bad_nxt;
    e_bad_r   <= e_bad_nxt;
    eth_r     <= eth_nxt;
    hi_r      <= hi_nxt;
    run_r     <= run_nxt;
    rep_r     <= rep_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DEPTH)) else $error("fill exceeds store depth");
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(head_r) < DEPTH) else $error("head pointer out of range");
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_v_r) else $error("report pending while idle");
  a_report_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(n_r) <= MAXR) else $error("too many reports for one word");
  a_no_write_parse: assert property (@(posedge clk) disable iff (!rst_n)
    re |-> !we) else $error("store written during parse");

endmodule

// ===== hw/rtl/spi_rx_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// Each frame checked runs ten header reads (issue and capture states), two end-marker reads,
// two EtherType reads and the decision states; a resync scan reads the store byte by byte.
// A received word below the parse fill passes idle, top and done, a flush word idle, emit
// and done; words go in only in idle; the single store read port and output stalls pace it.
// Reset (rst_n low, synchronous): the store empties, no report is held, the IPv6 flag
// clears and the registers return to 1536, 64 and 60. Store contents need no clearing.
module spi_rx_frame_deframer_top #(
  parameter int STORE_DEPTH = 2048,
  parameter int MAX_REPORTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] eth_length, [31:16] ether_type, [33:32] route,
                                  // [44:34] skipped_bytes, [45] ipv6_seen, [47:46] zero
  output logic [3:0]  out_tuser,  // [3:0] status
  output logic        out_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(STORE_DEPTH);

  // Configuration registers; any 11-bit value is taken as written.
  spf_pkg::cfg_t cfg_r;
  logic          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_packet_len <= 11'd1536;
      cfg_r.min_buffer_len <= 11'd64;
      cfg_r.min_eth_len    <= 11'd60;
    end else if (cfg_we) begin
      case (paddr[3:2])
        spf_pkg::REG_MAX_PKT: cfg_r.max_packet_len <= pwdata[10:0];
        spf_pkg::REG_MIN_BUF: cfg_r.min_buffer_len <= pwdata[10:0];
        spf_pkg::REG_MIN_ETH: cfg_r.min_eth_len    <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      spf_pkg::REG_MAX_PKT: prdata = {21'd0, cfg_r.max_packet_len};
      spf_pkg::REG_MIN_BUF: prdata = {21'd0, cfg_r.min_buffer_len};
      spf_pkg::REG_MIN_ETH: prdata = {21'd0, cfg_r.min_eth_len};
      default:              prdata = 32'd0;
    endcase
  end

  // Store ports between the sequencer and the memory.
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  spf_store #(.DEPTH(STORE_DEPTH)) u_store (
    .clk, .we, .waddr, .wdata, .re, .raddr, .rdata
  );

  // Reports leave the sequencer through a one-deep staging slot, so the last flag can
  // be set once the parse loop ends, then through the output register.
  logic          push, out_free;
  spf_pkg::rep_t push_rep, out_rep;

  spf_ctrl #(.DEPTH(STORE_DEPTH), .MAXR(MAX_REPORTS)) u_ctrl (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_func(in_tuser[0]), .in_byte(in_tdata),
    .we, .waddr, .wdata, .re, .raddr, .rdata,
    .push, .push_rep, .out_free
  );

  spf_outreg u_out (
    .clk, .rst_n, .push, .push_rep, .free(out_free),
    .ready(out_tready), .valid(out_tvalid), .rep(out_rep)
  );

  assign out_tdata = {2'b00, out_rep.ipv6_seen, out_rep.skipped_bytes, out_rep.route,
                      out_rep.ether_type, out_rep.eth_length};
  assign out_tuser = out_rep.status;
  assign out_tlast = out_rep.last;

endmodule

// ===== dv/tb_spi_rx_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the SPI receive deframer: frames, errors, resyncs and flushes.
// Depends on spf_pkg and spi_rx_frame_deframer_top; needs no files or arguments.
module tb_spi_rx_frame_deframer_top;

  localparam int STORE_DEPTH = 2048;
  localparam int MAX_REPORTS = 16;
  // Longest internal work after the last report: a resync scan of a full store.
  localparam int SETTLE_CYCLES = 4500;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always #1 clk = ~clk;

  spi_rx_frame_deframer_top #(
    .STORE_DEPTH(STORE_DEPTH),
    .MAX_REPORTS(MAX_REPORTS)
  ) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // Shadow of the block: byte store, fill level, sticky IPv6 flag, a held
  // resync or flush report, and the three registers.
  logic [7:0] shadow_store [STORE_DEPTH];
  int         shadow_fill = 0;
  bit         shadow_ipv6 = 0;
  bit         held_valid = 0;
  logic [3:0] held_status = spf_pkg::ST_OK;
  int         held_skip = 0;
  int         max_pkt = 1536;
  int         min_buf = 64;
  int         min_eth = 60;

  spf_pkg::rep_t due_reports [$];   // reports predicted but not yet seen on the output
  int   word_count = 0;
  int   report_count = 0;
  int   frame_count = 0;
  int   err_count = 0;
  bit   quiet = 0;         // no random idling on either side
  int   hold_reqs = 0;     // bumped by a test to ask the receiver for a long hold-off
  int   hold_seen = 0;
  int   hold_left = 0;
  int   stall_left = 0;

  function automatic spf_pkg::rep_t make_report(logic [3:0] st, int eth, logic [15:0] et,
                                                logic [1:0] rt, int skip);
    spf_pkg::rep_t r;
    r.status = st;
    r.eth_length = eth[15:0];
    r.ether_type = et;
    r.route = rt;
    r.skipped_bytes = (skip > 2047) ? 11'd2047 : skip[10:0];
    r.ipv6_seen = shadow_ipv6;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void drop_front(int k);
    if (k >= shadow_fill) begin
      shadow_fill = 0;
      return;
    end
    for (int i = 0; i < shadow_fill - k; i++) shadow_store[i] = shadow_store[i + k];
    shadow_fill -= k;
  endfunction

  function automatic bit sof_at(int ofs);
    return shadow_store[ofs] == spf_pkg::SOF_BYTE && shadow_store[ofs + 1] == spf_pkg::SOF_BYTE &&
           shadow_store[ofs + 2] == spf_pkg::SOF_BYTE &&
           shadow_store[ofs + 3] == spf_pkg::SOF_BYTE;
  endfunction

  // Verdict on the frame at the head of the store: -1 while it is incomplete.
  function automatic int frame_verdict(output int eth, output int total);
    longint pl;
    pl = {shadow_store[0], shadow_store[1], shadow_store[2], shadow_store[3]};
    eth = {shadow_store[9], shadow_store[8]};
    total = 0;
    if (pl > max_pkt || pl + 4 > STORE_DEPTH) return spf_pkg::ST_PKT_LONG;
    if (min_buf >= 4 && pl < min_buf - 4) return spf_pkg::ST_PKT_SHORT;
    if (!sof_at(4)) return spf_pkg::ST_SOF_BAD;
    if (shadow_fill < pl + 4) return -1;
    if (shadow_store[pl + 2] != spf_pkg::EOF_BYTE || shadow_store[pl + 3] != spf_pkg::EOF_BYTE)
      return spf_pkg::ST_EOF_BAD;
    if (eth < min_eth) return spf_pkg::ST_ETH_SHORT;
    if (eth > max_pkt) return spf_pkg::ST_ETH_LONG;
    total = int'(pl) + 4;
    return spf_pkg::ST_OK;
  endfunction

  // Works out every report that one accepted word causes and queues them.
  task automatic deframe_word(bit flush, logic [7:0] rx);
    spf_pkg::rep_t reps [$];
    int          eth, total, st, i;
    bit          found;
    logic [15:0] et;
    logic [1:0]  rt;
    if (flush) begin
      reps.push_back(make_report(spf_pkg::ST_FLUSHED, 0, '0, spf_pkg::RT_HOMEPLUG,
                                 shadow_fill));
      shadow_fill = 0;
      held_valid = 0;
    end else begin
      if (shadow_fill < STORE_DEPTH) begin
        shadow_store[shadow_fill] = rx;
        shadow_fill++;
      end
      while (reps.size() < MAX_REPORTS) begin
        if (held_valid) begin
          reps.push_back(make_report(held_status, 0, '0, spf_pkg::RT_HOMEPLUG, held_skip));
          held_valid = 0;
          continue;
        end
        if (shadow_fill < min_buf || shadow_fill < spf_pkg::HDR_BYTES) break;
        st = frame_verdict(eth, total);
        if (st < 0) break;
        if (st == spf_pkg::ST_OK) begin
          et = {(spf_pkg::ET_OFS < total) ? shadow_store[spf_pkg::ET_OFS] : 8'h00,
                (spf_pkg::ET_OFS + 1 < total) ? shadow_store[spf_pkg::ET_OFS + 1] : 8'h00};
          rt = spf_pkg::RT_OTHER;
          if (et == spf_pkg::ET_HOMEPLUG) rt = spf_pkg::RT_HOMEPLUG;
          else if (et == spf_pkg::ET_IPV6) begin
            rt = spf_pkg::RT_IPV6;
            shadow_ipv6 = 1;
          end else if (et == spf_pkg::ET_IPV4) rt = spf_pkg::RT_IPV4;
          reps.push_back(make_report(spf_pkg::ST_OK, eth, et, rt, 0));
          drop_front(total);
          continue;
        end
        reps.push_back(make_report(st[3:0], eth, '0, spf_pkg::RT_HOMEPLUG, 0));
        // Look for the next start marker past the head; otherwise drop everything.
        found = 0;
        for (i = 1; i + 8 <= shadow_fill; i++) begin
          if (sof_at(i + 4)) begin
            found = 1;
            break;
          end
        end
        if (found) begin
          drop_front(i);
          held_status = spf_pkg::ST_RESYNC;
          held_skip = i;
        end else begin
          held_status = spf_pkg::ST_FLUSHED;
          held_skip = shadow_fill;
          shadow_fill = 0;
        end
        held_valid = 1;
      end
    end
    if (reps.size() > 0) reps[reps.size() - 1].last = 1'b1;
    foreach (reps[k]) due_reports.push_back(reps[k]);
    report_count += reps.size();
  endtask

  // Result checker: each accepted report against the oldest prediction.
  function automatic void log_mismatch(string what, spf_pkg::rep_t want, spf_pkg::rep_t got);
    err_count++;
    if (err_count <= 10)
      $display("%0t mismatch (%s): expected st=%0d eth=%h et=%h rt=%0d skip=%0d v6=%0b",
               $realtime, what, want.status, want.eth_length, want.ether_type, want.route,
               want.skipped_bytes, want.ipv6_seen, " last=%0b,", want.last);
    if (err_count <= 10)
      $display("    got st=%0d eth=%h et=%h rt=%0d skip=%0d v6=%0b last=%0b", got.status,
               got.eth_length, got.ether_type, got.route, got.skipped_bytes, got.ipv6_seen,
               got.last);
  endfunction

  always @(posedge clk) begin
    spf_pkg::rep_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.eth_length = out_tdata[15:0];
      got.ether_type = out_tdata[31:16];
      got.route = out_tdata[33:32];
      got.skipped_bytes = out_tdata[44:34];
      got.ipv6_seen = out_tdata[45];
      got.last = out_tlast;
      if (due_reports.size() == 0) begin
        want = '0;
        log_mismatch("unexpected report", want, got);
      end else begin
        want = due_reports.pop_front();
        if (got.status !== want.status || got.eth_length !== want.eth_length ||
            got.ether_type !== want.ether_type || got.route !== want.route ||
            got.skipped_bytes !== want.skipped_bytes || got.ipv6_seen !== want.ipv6_seen ||
            got.last !== want.last)
          log_mismatch("field", want, got);
      end
    end
  end

  // Receiver: random stall bursts, plus a long counted hold-off when a test asks.
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Offers one word and waits for it to be taken. Starts and ends on a falling edge;
  // tvalid stays high afterwards so back-to-back words need no gap.
  task automatic send_word(bit flush, logic [7:0] rx);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = flush;
    in_tdata = rx;
    do @(posedge clk); while (!in_tready);
    deframe_word(flush, rx);
    word_count++;
    @(negedge clk);
  endtask

  task automatic send_noise(int n);
    repeat (n) send_word(1'b0, 8'($urandom));
  endtask

  // Builds one frame of packet length len and sends it. Frames whose length the
  // block rejects up front, and those shorter than 12, are cut to their header.
  task automatic send_frame(int len, int eth, logic [15:0] et, bit bad_sof = 0,
                            bit bad_eof = 0);
    logic [7:0] bytes [$];
    int n, pos;
    n = (len > max_pkt || len < min_buf - 4 || len < 12) ? spf_pkg::HDR_BYTES : len + 4;
    for (int i = 0; i < n; i++) bytes.push_back(8'($urandom));
    if (spf_pkg::ET_OFS + 1 < n) begin
      bytes[spf_pkg::ET_OFS] = et[15:8];
      bytes[spf_pkg::ET_OFS + 1] = et[7:0];
    end
    if (n == len + 4) begin
      bytes[n - 2] = spf_pkg::EOF_BYTE;
      bytes[n - 1] = spf_pkg::EOF_BYTE;
      if (bad_eof) bytes[n - 1 - $urandom_range(0, 1)] = 8'($urandom_range(0, 84));
    end
    {bytes[0], bytes[1], bytes[2], bytes[3]} = len;
    for (int i = 4; i < 8; i++) bytes[i] = spf_pkg::SOF_BYTE;
    if (bad_sof) begin
      pos = $urandom_range(4, 7);
      bytes[pos] = 8'($urandom_range(0, 169));
    end
    bytes[8] = eth[7:0];
    bytes[9] = eth[15:8];
    foreach (bytes[i]) send_word(1'b0, bytes[i]);
    frame_count++;
  endtask

  // Waits until every predicted report has arrived and the block has settled.
  task automatic drain(int settle);
    in_tvalid = 1'b0;
    while (due_reports.size() > 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    in_tvalid = 1'b0;
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      spf_pkg::REG_MAX_PKT: max_pkt = value & 'h7FF;
      spf_pkg::REG_MIN_BUF: min_buf = value & 'h7FF;
      default:              min_eth = value & 'h7FF;
    endcase
  endtask

  task automatic set_config(int mx, int mb, int me);
    drain(SETTLE_CYCLES);
    write_reg(spf_pkg::REG_MAX_PKT, mx);
    write_reg(spf_pkg::REG_MIN_BUF, mb);
    write_reg(spf_pkg::REG_MIN_ETH, me);
  endtask

  // A good frame with random sizes inside the current limits.
  task automatic send_good_frame(logic [15:0] et);
    int lo, len, eth;
    lo = (min_buf - 4 > 12) ? min_buf - 4 : 12;
    len = $urandom_range(lo, (lo + 12 < max_pkt) ? lo + 12 : max_pkt);
    eth = $urandom_range(min_eth, (min_eth + 40 < max_pkt) ? min_eth + 40 : max_pkt);
    send_frame(len, eth, et);
  endtask

  function automatic logic [15:0] pick_ether_type();
    case ($urandom_range(0, 3))
      0: return spf_pkg::ET_HOMEPLUG;
      1: return spf_pkg::ET_IPV6;
      2: return spf_pkg::ET_IPV4;
      default: return 16'($urandom);
    endcase
  endfunction

  // Reset values: a flush of the empty store and one default-size frame.
  task automatic test_reset_defaults();
    send_word(1'b1, 8'h00);
    send_frame(60, 60, spf_pkg::ET_HOMEPLUG);
  endtask

  // Each route class, and a frame too short to hold an EtherType.
  task automatic test_routes();
    send_frame(22, 20, spf_pkg::ET_HOMEPLUG);
    send_frame(22, 64, spf_pkg::ET_IPV6);
    send_frame(22, 14, spf_pkg::ET_IPV4);
    send_frame(22, 33, 16'hFFFF);
    send_frame(12, 14, spf_pkg::ET_IPV6);
  endtask

  // Every rejection code, each followed by a resync or a flush of the rest of the store.
  task automatic test_rejects();
    send_frame(2047, 20, spf_pkg::ET_IPV4);
    send_frame(11, 20, spf_pkg::ET_IPV4);
    send_frame(12, 20, spf_pkg::ET_IPV4, 1'b1, 1'b0);
    send_frame(12, 20, spf_pkg::ET_IPV4, 1'b0, 1'b1);
    send_frame(12, 13, spf_pkg::ET_IPV4);
    send_frame(12, 65, spf_pkg::ET_IPV4);
  endtask

  // A run of start bytes makes every rejection find a marker one byte on, giving a
  // long chain of resync reports.
  task automatic test_resync_chain();
    repeat (4) send_word(1'b0, 8'hFF);
    repeat (16) send_word(1'b0, spf_pkg::SOF_BYTE);
    send_noise(3);
    send_frame(12, 20, spf_pkg::ET_HOMEPLUG);
    repeat (5) send_word(1'b0, 8'h00);
    send_word(1'b1, 8'hFF);
  endtask

  // The receiver holds off while short frames keep coming, so the block backs up;
  // afterwards the sender waits for every report.
  task automatic test_backpressure();
    hold_reqs++;
    repeat (4) send_frame(12, 14, pick_ether_type());
    drain(0);
  endtask

  task automatic test_random(int word_goal, int report_goal);
    int pick;
    quiet = 0;
    while (word_count < word_goal || report_count < report_goal) begin
      if (word_count > word_goal - 15) quiet = 1;
      pick = $urandom_range(0, 99);
      if (pick < 65) send_good_frame(pick_ether_type());
      else if (pick < 68) send_frame($urandom_range(max_pkt + 1, 2047), 20, spf_pkg::ET_IPV4);
      else if (pick < 71) send_frame($urandom_range(0, 11), 20, spf_pkg::ET_IPV4);
      else if (pick < 75) send_frame(20, 20, spf_pkg::ET_IPV4, 1'b1, 1'b0);
      else if (pick < 79) send_frame(20, 20, spf_pkg::ET_IPV4, 1'b0, 1'b1);
      else if (pick < 82) send_frame(20, $urandom_range(0, min_eth - 1), spf_pkg::ET_IPV4);
      else if (pick < 85) send_frame(20, $urandom_range(max_pkt + 1, 65535), spf_pkg::ET_IPV4);
      else if (pick < 94) send_noise($urandom_range(1, 6));
      else send_word(1'b1, 8'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    set_config(64, 16, 14);
    test_routes();
    test_rejects();
    test_resync_chain();
    test_backpressure();
    send_noise(4);
    send_word(1'b1, 8'h00);   // flush of a partly filled store
    set_config(200, 16, 14);
    test_random(word_count + 15, 0);
    set_config($urandom_range(64, 300), $urandom_range(16, 40), $urandom_range(14, 60));
    test_random(word_count + 15, 0);

    drain(SETTLE_CYCLES);
    $display("Covered %0d words, %0d frames and %0d reports over four register settings,",
             word_count, frame_count, report_count);
    $display("with every reject code, resync chains, flushes and a long output stall.");
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/spf_pkg.sv
hw/rtl/spf_store.sv
hw/rtl/spf_outreg.sv
hw/rtl/spf_ctrl.sv
hw/rtl/spi_rx_frame_deframer_top.sv
dv/tb_spi_rx_frame_deframer_top.sv
